[sv/spk_pkg.sv]
`timescale 1ns / 1ps

package spk_pkg;

   localparam int ROUNDS_MAX_DEF = 22;
   localparam int WORD_W         = 16;
   localparam int RC_W           = 5;
   localparam int CSR_IDX_W      = 3;
   localparam int ROT_ALPHA      = 7;
   localparam int ROT_BETA       = 2;

   // register map
   localparam logic [CSR_IDX_W-1:0] CSR_KEY_WORD_0  = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_KEY_WORD_1  = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_KEY_WORD_2  = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_KEY_WORD_3  = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_ROUND_COUNT = 3'd4;

   localparam logic OP_ENCRYPT = 1'b0;
   localparam logic OP_DECRYPT = 1'b1;

   typedef struct packed {
      logic              opcode;
      logic [WORD_W-1:0] block_left;
      logic [WORD_W-1:0] block_right;
   } req_type;

   typedef struct packed {
      logic [WORD_W-1:0] result_left;
      logic [WORD_W-1:0] result_right;
   } rsp_type;

   function automatic logic [WORD_W-1:0] rotr_alpha(input logic [WORD_W-1:0] v);
      return {v[ROT_ALPHA-1:0], v[WORD_W-1:ROT_ALPHA]};
   endfunction

   function automatic logic [WORD_W-1:0] rotl_alpha(input logic [WORD_W-1:0] v);
      return {v[WORD_W-ROT_ALPHA-1:0], v[WORD_W-1:WORD_W-ROT_ALPHA]};
   endfunction

   function automatic logic [WORD_W-1:0] rotr_beta(input logic [WORD_W-1:0] v);
      return {v[ROT_BETA-1:0], v[WORD_W-1:ROT_BETA]};
   endfunction

   function automatic logic [WORD_W-1:0] rotl_beta(input logic [WORD_W-1:0] v);
      return {v[WORD_W-ROT_BETA-1:0], v[WORD_W-1:WORD_W-ROT_BETA]};
   endfunction

   // forward round, returns {x, y}
   function automatic logic [2*WORD_W-1:0] enc_round(input logic [WORD_W-1:0] x,
                                                     input logic [WORD_W-1:0] y,
                                                     input logic [WORD_W-1:0] rk);
      logic [WORD_W-1:0] xn;
      logic [WORD_W-1:0] yn;
      xn = (rotr_alpha(x) + y) ^ rk;
      yn = rotl_beta(y) ^ xn;
      return {xn, yn};
   endfunction

   // inverse round, returns {x, y}
   function automatic logic [2*WORD_W-1:0] dec_round(input logic [WORD_W-1:0] x,
                                                     input logic [WORD_W-1:0] y,
                                                     input logic [WORD_W-1:0] rk);
      logic [WORD_W-1:0] xn;
      logic [WORD_W-1:0] yn;
      yn = rotr_beta(y ^ x);
      xn = rotl_alpha((x ^ rk) - yn);
      return {xn, yn};
   endfunction

endpackage

[sv/speck32_64_reduced_round_cipher.sv]
`timescale 1ns / 1ps

// Speck32/64 block cipher, 1 to ROUNDS_MAX rounds (round_count saturates at
// both ends). Key words and round count are written through the csr_ port,
// which is always ready. Each write of a key word, and reset, starts a key
// schedule pass that writes the round key memory one key per cycle, during
// which req_ready is low; a new key write restarts the pass. A block beat on
// req_ starts with a read of its first round key from the single-port-read
// key memory and then runs one ARX round per cycle; the next block is taken
// once the round loop is free. The result sits in an output register, so
// the core can start the next block while rsp_ waits for ready. Decrypt
// walks the keys from n-1 down to 0.
module speck32_64_reduced_round_cipher
   import spk_pkg::*;
#(
   parameter int ROUNDS_MAX = ROUNDS_MAX_DEF
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_ready,
   input  req_type              req_payload,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   output rsp_type              rsp_payload,
   input  logic                 csr_valid,
   output logic                 csr_ready,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [WORD_W-1:0]    csr_data
);

   localparam int IDX_W    = (ROUNDS_MAX > 1) ? $clog2(ROUNDS_MAX) : 1;
   localparam int CNT_W    = $clog2(ROUNDS_MAX + 1);
   localparam int EXP_LAST = (ROUNDS_MAX > 1) ? ROUNDS_MAX - 2 : 0;

   typedef enum logic [4:0] {
      ST_IDLE   = 5'b00001,
      ST_LOAD   = 5'b00010,
      ST_EXPAND = 5'b00100,
      ST_RUN    = 5'b01000,
      ST_HOLD   = 5'b10000
   } state_type;

   state_type state_ff, state_in;

   // configuration
   logic [WORD_W-1:0] key0_ff, key1_ff, key2_ff, key3_ff;
   logic [RC_W-1:0]   rounds_ff;
   logic              csr_fire;
   logic              key_wr;

   // round key memory
   logic [WORD_W-1:0] key_mem [ROUNDS_MAX];
   logic              mem_we;
   logic [IDX_W-1:0]  mem_waddr;
   logic [WORD_W-1:0] mem_wdata;
   logic              mem_re;
   logic [IDX_W-1:0]  mem_raddr;
   logic [WORD_W-1:0] rk_ff;

   // key schedule: k and a three-deep queue of l words
   logic [WORD_W-1:0] k_ff, k_in;
   logic [WORD_W-1:0] q0_ff, q0_in, q1_ff, q1_in, q2_ff, q2_in;
   logic [IDX_W-1:0]  exp_i_ff, exp_i_in;
   logic [WORD_W-1:0] l_new, k_new;

   // round loop
   logic [WORD_W-1:0] x_ff, x_in, y_ff, y_in;
   logic              op_ff, op_in;
   logic [CNT_W-1:0]  cnt_ff, cnt_in;
   logic [IDX_W-1:0]  idx_ff, idx_in;
   logic [2*WORD_W-1:0] rnd;

   // effective round count
   logic [RC_W:0]     rc_ext;
   logic [RC_W:0]     n_wide;
   logic [CNT_W-1:0]  rounds_eff;
   logic [CNT_W-1:0]  n_m1;

   // output register
   logic    rsp_valid_ff, rsp_valid_in;
   rsp_type rsp_data_ff, rsp_data_in;
   logic    rsp_load;
   logic    out_free;
   logic    req_fire;

   assign csr_ready = 1'b1;
   assign csr_fire  = csr_valid & csr_ready;
   assign key_wr    = csr_fire && (csr_index == CSR_KEY_WORD_0 || csr_index == CSR_KEY_WORD_1 ||
                                   csr_index == CSR_KEY_WORD_2 || csr_index == CSR_KEY_WORD_3);

   assign req_ready   = (state_ff == ST_IDLE);
   assign req_fire    = req_valid & req_ready;
   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_data_ff;
   assign out_free    = ~rsp_valid_ff | rsp_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         key0_ff   <= '0;
         key1_ff   <= '0;
         key2_ff   <= '0;
         key3_ff   <= '0;
         rounds_ff <= RC_W'(22);
      end else if (csr_fire) begin
         unique case (csr_index)
            CSR_KEY_WORD_0:  key0_ff   <= csr_data;
            CSR_KEY_WORD_1:  key1_ff   <= csr_data;
            CSR_KEY_WORD_2:  key2_ff   <= csr_data;
            CSR_KEY_WORD_3:  key3_ff   <= csr_data;
            CSR_ROUND_COUNT: rounds_ff <= csr_data[RC_W-1:0];
            default: ;
         endcase
      end
   end

   // clamp to 1..ROUNDS_MAX
   always_comb begin
      rc_ext = {1'b0, rounds_ff};
      if (rc_ext == '0) begin
         n_wide = (RC_W+1)'(1);
      end else if (rc_ext > (RC_W+1)'(ROUNDS_MAX)) begin
         n_wide = (RC_W+1)'(ROUNDS_MAX);
      end else begin
         n_wide = rc_ext;
      end
      rounds_eff = n_wide[CNT_W-1:0];
      n_m1       = rounds_eff - CNT_W'(1);
   end

   // one key schedule step
   assign l_new = (rotr_alpha(q0_ff) + k_ff) ^ WORD_W'(exp_i_ff);
   assign k_new = rotl_beta(k_ff) ^ l_new;

   assign rnd = (op_ff == OP_DECRYPT) ? dec_round(x_ff, y_ff, rk_ff)
                                      : enc_round(x_ff, y_ff, rk_ff);

   always_comb begin
      state_in    = state_ff;
      k_in        = k_ff;
      q0_in       = q0_ff;
      q1_in       = q1_ff;
      q2_in       = q2_ff;
      exp_i_in    = exp_i_ff;
      x_in        = x_ff;
      y_in        = y_ff;
      op_in       = op_ff;
      cnt_in      = cnt_ff;
      idx_in      = idx_ff;
      mem_we      = 1'b0;
      mem_waddr   = '0;
      mem_wdata   = k_new;
      mem_re      = 1'b0;
      mem_raddr   = idx_ff;
      rsp_load    = 1'b0;
      rsp_data_in = rsp_data_ff;

      unique case (state_ff)
         ST_LOAD: begin
            mem_we    = 1'b1;
            mem_waddr = '0;
            mem_wdata = key3_ff;
            k_in      = key3_ff;
            q0_in     = key2_ff;
            q1_in     = key1_ff;
            q2_in     = key0_ff;
            exp_i_in  = '0;
            state_in  = (ROUNDS_MAX > 1) ? ST_EXPAND : ST_IDLE;
         end
         ST_EXPAND: begin
            mem_we    = 1'b1;
            mem_waddr = exp_i_ff + IDX_W'(1);
            mem_wdata = k_new;
            k_in      = k_new;
            q0_in     = q1_ff;
            q1_in     = q2_ff;
            q2_in     = l_new;
            exp_i_in  = exp_i_ff + IDX_W'(1);
            if (exp_i_ff == IDX_W'(EXP_LAST)) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (req_fire) begin
               op_in  = req_payload.opcode;
               x_in   = req_payload.block_left;
               y_in   = req_payload.block_right;
               cnt_in = rounds_eff;
               mem_re = 1'b1;
               if (req_payload.opcode == OP_DECRYPT) begin
                  mem_raddr = n_m1[IDX_W-1:0];
                  idx_in    = n_m1[IDX_W-1:0] - IDX_W'(1);
               end else begin
                  mem_raddr = '0;
                  idx_in    = IDX_W'(1);
               end
               state_in = ST_RUN;
            end
         end
         ST_RUN: begin
            x_in   = rnd[2*WORD_W-1:WORD_W];
            y_in   = rnd[WORD_W-1:0];
            cnt_in = cnt_ff - CNT_W'(1);
            if (cnt_ff != CNT_W'(1)) begin
               // fetch the key for the following round
               mem_re    = 1'b1;
               mem_raddr = idx_ff;
               idx_in    = (op_ff == OP_DECRYPT) ? idx_ff - IDX_W'(1) : idx_ff + IDX_W'(1);
            end else if (out_free) begin
               rsp_load                 = 1'b1;
               rsp_data_in.result_left  = rnd[2*WORD_W-1:WORD_W];
               rsp_data_in.result_right = rnd[WORD_W-1:0];
               state_in                 = ST_IDLE;
            end else begin
               state_in = ST_HOLD;
            end
         end
         ST_HOLD: begin
            if (out_free) begin
               rsp_load                 = 1'b1;
               rsp_data_in.result_left  = x_ff;
               rsp_data_in.result_right = y_ff;
               state_in                 = ST_IDLE;
            end
         end
         default: state_in = ST_LOAD;
      endcase

      // any key change reruns the schedule from the top
      if (key_wr) begin
         state_in = ST_LOAD;
      end
   end

   assign rsp_valid_in = rsp_load | (rsp_valid_ff & ~rsp_ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_LOAD;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      k_ff        <= k_in;
      q0_ff       <= q0_in;
      q1_ff       <= q1_in;
      q2_ff       <= q2_in;
      exp_i_ff    <= exp_i_in;
      x_ff        <= x_in;
      y_ff        <= y_in;
      op_ff       <= op_in;
      cnt_ff      <= cnt_in;
      idx_ff      <= idx_in;
      rsp_data_ff <= rsp_data_in;
   end

   // round key memory, registered read
   always_ff @(posedge clock) begin
      if (mem_we) begin
         key_mem[mem_waddr] <= mem_wdata;
      end
   end

   always_ff @(posedge clock) begin
      if (mem_re) begin
         rk_ff <= key_mem[mem_raddr];
      end
   end

endmodule

[sv/spk_checker.sv]
`timescale 1ns / 1ps

module spk_checker
   import spk_pkg::*;
(
   input logic                 clock,
   input logic                 reset,
   input logic                 req_valid,
   input logic                 req_ready,
   input logic                 rsp_valid,
   input logic                 rsp_ready,
   input rsp_type              rsp_payload,
   input logic                 csr_valid,
   input logic                 csr_ready,
   input logic [CSR_IDX_W-1:0] csr_index
);

   // a stalled result beat holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_payload))
      else $error("rsp beat dropped or changed while stalled");

   // key schedule runs right after reset
   a_reset_busy: assert property (@(posedge clock)
      reset |=> !req_ready)
      else $error("req_ready high during key schedule after reset");

   // one block in the round loop at a time
   a_one_block: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("second block taken while rounds in progress");

   // key write triggers a new schedule pass
   a_key_rekey: assert property (@(posedge clock) disable iff (reset)
      csr_valid && csr_ready &&
      (csr_index == CSR_KEY_WORD_0 || csr_index == CSR_KEY_WORD_1 ||
       csr_index == CSR_KEY_WORD_2 || csr_index == CSR_KEY_WORD_3) |=> !req_ready)
      else $error("key write did not hold off requests");

endmodule

bind speck32_64_reduced_round_cipher spk_checker u_spk_checker (.*);

[tb/sv/testbench.sv]
`timescale 1ns / 1ps

// Block-level check of the reduced-round Speck32/64 core.
//  - a directed table walks the corners: all-zero key after reset, the
//    published 22-round key/plaintext pair, one-round cases, round counts
//    below and above the legal range, and writes to unmapped indexes
//  - then ten random phases: registers rewritten while the core is idle,
//    followed by random blocks, part of them encrypt/decrypt round trips
//  - every result beat is checked against a local model of the cipher or a pinned result
module testbench;
   import spk_pkg::*;

   localparam int QUIET_LIMIT   = 600;   // cycles with no beat on any port
   localparam int PHASES        = 10;
   localparam int BLOCKS_PER_PH = 45;

   // indexes past the register map; the core must drop these writes
   localparam logic [CSR_IDX_W-1:0] CSR_UNMAPPED_FIRST = 3'd5;
   localparam logic [CSR_IDX_W-1:0] CSR_UNMAPPED_LAST  = 3'd7;

   typedef enum logic {ROW_WRITE, ROW_BLOCK} row_kind_type;
   typedef enum logic [1:0] {RX_OPEN, RX_CHOPPY, RX_BLOCKED} rx_mode_type;

   typedef struct {
      row_kind_type          kind;
      logic [CSR_IDX_W-1:0]  index;
      logic [WORD_W-1:0]     data;
      req_type               blk;
      bit                    pinned;   // result typed in below, not computed
      rsp_type               want;
   } stim_row_type;

   logic                 clock       = 1'b0;
   logic                 reset       = 1'b1;
   logic                 req_valid   = 1'b0;
   logic                 req_ready;
   req_type              req_payload = '0;
   logic                 rsp_valid;
   logic                 rsp_ready   = 1'b0;
   rsp_type              rsp_payload;
   logic                 csr_valid   = 1'b0;
   logic                 csr_ready;
   logic [CSR_IDX_W-1:0] csr_index   = '0;
   logic [WORD_W-1:0]    csr_data    = '0;

   // local copy of the core's configuration and key schedule
   logic [WORD_W-1:0] key_words [4];
   logic [RC_W-1:0]   rounds_cfg;
   logic [WORD_W-1:0] sched_keys [ROUNDS_MAX_DEF];

   rsp_type      expected_blocks [$];
   stim_row_type directed_rows [$];
   int           errors      = 0;
   int           burst_left  = 0;
   int           quiet_cycles = 0;
   rx_mode_type  rx_mode     = RX_OPEN;
   int           rx_hold     = 0;

   speck32_64_reduced_round_cipher uut (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_payload (req_payload),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_payload (rsp_payload),
      .csr_valid   (csr_valid),
      .csr_ready   (csr_ready),
      .csr_index   (csr_index),
      .csr_data    (csr_data)
   );

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   // ---------------------------------------------------------------- model

   function automatic logic [WORD_W-1:0] ror16(input logic [WORD_W-1:0] v, input int r);
      return (v >> r) | (v << (WORD_W - r));
   endfunction

   function automatic logic [WORD_W-1:0] rol16(input logic [WORD_W-1:0] v, input int r);
      return (v << r) | (v >> (WORD_W - r));
   endfunction

   // key word 3 is round key zero; words 2, 1, 0 seed the l rotation in that order
   function automatic void schedule_round_keys();
      logic [WORD_W-1:0] k;
      logic [WORD_W-1:0] l [3];
      int s;
      k    = key_words[3];
      l[0] = key_words[2];
      l[1] = key_words[1];
      l[2] = key_words[0];
      sched_keys[0] = k;
      for (int i = 0; i < ROUNDS_MAX_DEF - 1; i++) begin
         s    = i % 3;
         l[s] = (ror16(l[s], ROT_ALPHA) + k) ^ WORD_W'(i);
         k    = rol16(k, ROT_BETA) ^ l[s];
         sched_keys[i + 1] = k;
      end
   endfunction

   function automatic void apply_register(input logic [CSR_IDX_W-1:0] idx,
                                          input logic [WORD_W-1:0] data);
      case (idx)
         CSR_KEY_WORD_0:  begin key_words[0] = data; schedule_round_keys(); end
         CSR_KEY_WORD_1:  begin key_words[1] = data; schedule_round_keys(); end
         CSR_KEY_WORD_2:  begin key_words[2] = data; schedule_round_keys(); end
         CSR_KEY_WORD_3:  begin key_words[3] = data; schedule_round_keys(); end
         CSR_ROUND_COUNT: rounds_cfg = data[RC_W-1:0];   // key store untouched
         default: ;                                        // unmapped: dropped
      endcase
   endfunction

   // round count clamps to 1..ROUNDS_MAX; decrypt walks the keys backwards
   function automatic rsp_type cipher_block(input req_type b);
      logic [WORD_W-1:0] x;
      logic [WORD_W-1:0] y;
      int n;
      rsp_type r;
      x = b.block_left;
      y = b.block_right;
      n = rounds_cfg;
      if (n < 1) n = 1;
      if (n > ROUNDS_MAX_DEF) n = ROUNDS_MAX_DEF;
      if (b.opcode == OP_ENCRYPT) begin
         for (int i = 0; i < n; i++) begin
            x = (ror16(x, ROT_ALPHA) + y) ^ sched_keys[i];
            y = rol16(y, ROT_BETA) ^ x;
         end
      end else begin
         for (int i = n - 1; i >= 0; i--) begin
            y = ror16(y ^ x, ROT_BETA);
            x = rol16((x ^ sched_keys[i]) - y, ROT_ALPHA);
         end
      end
      r.result_left  = x;
      r.result_right = y;
      return r;
   endfunction

   // ------------------------------------------------------- directed table

   function automatic void add_write(input logic [CSR_IDX_W-1:0] idx,
                                     input logic [WORD_W-1:0] data);
      stim_row_type row;
      row = '{kind: ROW_WRITE, index: idx, data: data, blk: '0, pinned: 1'b0, want: '0};
      directed_rows.push_back(row);
   endfunction

   function automatic void add_block(input logic op, input logic [WORD_W-1:0] l,
                                     input logic [WORD_W-1:0] r);
      stim_row_type row;
      row = '{kind: ROW_BLOCK, index: '0, data: '0, blk: {op, l, r}, pinned: 1'b0,
              want: '0};
      directed_rows.push_back(row);
   endfunction

   function automatic void add_pinned(input logic op, input logic [WORD_W-1:0] l,
                                      input logic [WORD_W-1:0] r,
                                      input logic [WORD_W-1:0] wl,
                                      input logic [WORD_W-1:0] wr);
      stim_row_type row;
      row = '{kind: ROW_BLOCK, index: '0, data: '0, blk: {op, l, r}, pinned: 1'b1,
              want: {wl, wr}};
      directed_rows.push_back(row);
   endfunction

   // mostly random, with a fair share of all-zero and all-one words
   function automatic logic [WORD_W-1:0] pick_word();
      case ($urandom_range(0, 7))
         0:       return '0;
         1:       return '1;
         default: return WORD_W'($urandom);
      endcase
   endfunction

   // --------------------------------------------------------------- drivers

   // Sender works in bursts; valid stays up between beats of one burst and
   // may drop for a random gap between bursts. Inputs move on the falling edge.
   task automatic send_block(input req_type item, input bit pinned, input rsp_type want);
      int gap;
      if (burst_left == 0) begin
         gap        = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
         burst_left = $urandom_range(1, 16);
         if (gap != 0) begin
            @(negedge clock);
            req_valid = 1'b0;
            repeat (gap - 1) @(negedge clock);
         end
      end
      burst_left--;
      @(negedge clock);
      req_valid   = 1'b1;
      req_payload = item;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      // beat taken at this edge: queue what it must produce
      expected_blocks.push_back(pinned ? want : cipher_block(item));
   endtask

   // close the burst, then wait for every outstanding result; each block
   // gives exactly one result, so an empty queue means the core is idle
   task automatic wait_drained();
      @(negedge clock);
      req_valid  = 1'b0;
      burst_left = 0;
      while (expected_blocks.size() != 0) @(posedge clock);
   endtask

   task automatic write_register(input logic [CSR_IDX_W-1:0] idx,
                                 input logic [WORD_W-1:0] data);
      @(negedge clock);
      csr_valid = 1'b1;
      csr_index = idx;
      csr_data  = data;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      apply_register(idx, data);
      @(negedge clock);
      csr_valid = 1'b0;
   endtask

   // Receiver: segments of always-ready, coin-flip ready, and hard stalls.
   always @(negedge clock) begin
      if (rx_hold == 0) begin
         case ($urandom_range(0, 3))
            0, 1:    rx_mode = RX_OPEN;
            2:       rx_mode = RX_CHOPPY;
            default: rx_mode = RX_BLOCKED;
         endcase
         rx_hold = (rx_mode == RX_BLOCKED) ? $urandom_range(1, 24) : $urandom_range(4, 48);
      end
      rx_hold--;
      rsp_ready = (rx_mode == RX_OPEN)    ? 1'b1 :
                  (rx_mode == RX_BLOCKED) ? 1'b0 : 1'($urandom_range(0, 1));
   end

   // ------------------------------------------------------------- checking

   always @(posedge clock) begin : result_check
      rsp_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (expected_blocks.size() == 0) begin
            $error("result beat with nothing outstanding: %h", rsp_payload);
            errors++;
         end else begin
            want = expected_blocks.pop_front();
            if (rsp_payload.result_left !== want.result_left) begin
               $error("result_left: expected %h, got %h",
                      want.result_left, rsp_payload.result_left);
               errors++;
            end
            if (rsp_payload.result_right !== want.result_right) begin
               $error("result_right: expected %h, got %h",
                      want.result_right, rsp_payload.result_right);
               errors++;
            end
         end
      end
   end

   // Watchdog: any beat on any port counts as progress. Reset plus the
   // key schedule pass after it fit well inside the limit.
   always @(posedge clock) begin
      if ((req_valid && req_ready) || (rsp_valid && rsp_ready) || (csr_valid && csr_ready))
         quiet_cycles = 0;
      else
         quiet_cycles++;
      if (quiet_cycles == QUIET_LIMIT) begin
         $display("testbench: done, errors");
         $finish;
      end
   end

   // ------------------------------------------------------------- sequence

   initial begin
      stim_row_type row;
      req_type item;
      rsp_type last_out;
      bit      have_last;
      logic [WORD_W-1:0] rc;

      // model state after reset: zero key, full round count
      key_words  = '{default: '0};
      rounds_cfg = RC_W'(ROUNDS_MAX_DEF);
      schedule_round_keys();

      // all-zero key, 22 rounds: extremes of both halves, both directions
      add_block(OP_ENCRYPT, 16'h0000, 16'h0000);
      add_block(OP_DECRYPT, 16'h0000, 16'h0000);
      add_block(OP_ENCRYPT, 16'hFFFF, 16'hFFFF);
      add_block(OP_DECRYPT, 16'hFFFF, 16'hFFFF);
      add_block(OP_ENCRYPT, 16'hFFFF, 16'h0000);
      add_block(OP_DECRYPT, 16'h0000, 16'hFFFF);
      // published Speck32/64 pair: key 1918 1110 0908 0100
      add_write(CSR_KEY_WORD_0, 16'h1918);
      add_write(CSR_KEY_WORD_1, 16'h1110);
      add_write(CSR_KEY_WORD_2, 16'h0908);
      add_write(CSR_KEY_WORD_3, 16'h0100);
      add_pinned(OP_ENCRYPT, 16'h6574, 16'h694C, 16'hA868, 16'h42F2);
      add_pinned(OP_DECRYPT, 16'hA868, 16'h42F2, 16'h6574, 16'h694C);
      // zero rounds behaves as one
      add_write(CSR_ROUND_COUNT, 16'd0);
      add_block(OP_ENCRYPT, 16'h6574, 16'h694C);
      add_block(OP_DECRYPT, 16'h1234, 16'h5678);
      // one round, round key zero all ones: zero block maps to key, and back
      add_write(CSR_KEY_WORD_3, 16'hFFFF);
      add_write(CSR_ROUND_COUNT, 16'd1);
      add_pinned(OP_ENCRYPT, 16'h0000, 16'h0000, 16'hFFFF, 16'hFFFF);
      add_pinned(OP_DECRYPT, 16'hFFFF, 16'hFFFF, 16'h0000, 16'h0000);
      // counts above the maximum clamp to it
      add_write(CSR_ROUND_COUNT, 16'd31);
      add_block(OP_ENCRYPT, 16'hAAAA, 16'h5555);
      add_block(OP_DECRYPT, 16'h5555, 16'hAAAA);
      add_write(CSR_ROUND_COUNT, 16'd23);
      add_block(OP_ENCRYPT, 16'h8000, 16'h0001);
      // upper data bits are not part of the round count
      add_write(CSR_ROUND_COUNT, 16'hFFE2);
      add_block(OP_DECRYPT, 16'h8000, 16'h0001);
      // unmapped indexes change nothing
      add_write(CSR_UNMAPPED_FIRST, 16'hFFFF);
      add_write(CSR_UNMAPPED_LAST, 16'h0000);
      add_block(OP_ENCRYPT, 16'h0001, 16'h8000);
      // all-ones key at the full count, then back to all zeros
      add_write(CSR_KEY_WORD_0, 16'hFFFF);
      add_write(CSR_KEY_WORD_1, 16'hFFFF);
      add_write(CSR_KEY_WORD_2, 16'hFFFF);
      add_write(CSR_ROUND_COUNT, 16'd22);
      add_block(OP_ENCRYPT, 16'hFFFF, 16'hFFFF);
      add_block(OP_DECRYPT, 16'h0000, 16'h0000);
      add_write(CSR_KEY_WORD_0, 16'h0000);
      add_write(CSR_KEY_WORD_1, 16'h0000);
      add_write(CSR_KEY_WORD_2, 16'h0000);
      add_write(CSR_KEY_WORD_3, 16'h0000);
      add_block(OP_ENCRYPT, 16'h0000, 16'h0000);

      repeat (10) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      foreach (directed_rows[i]) begin
         row = directed_rows[i];
         if (row.kind == ROW_WRITE) begin
            wait_drained();
            write_register(row.index, row.data);
         end else begin
            send_block(row.blk, row.pinned, row.want);
         end
      end

      // random phases: new settings on an idle core, then a run of blocks
      for (int ph = 0; ph < PHASES; ph++) begin
         wait_drained();
         if ($urandom_range(0, 1)) write_register(CSR_KEY_WORD_0, pick_word());
         if ($urandom_range(0, 1)) write_register(CSR_KEY_WORD_1, pick_word());
         if ($urandom_range(0, 1)) write_register(CSR_KEY_WORD_2, pick_word());
         if ($urandom_range(0, 1)) write_register(CSR_KEY_WORD_3, pick_word());
         if ($urandom_range(0, 3) != 0) begin
            case ($urandom_range(0, 9))
               0:       rc = 16'd1;
               1:       rc = WORD_W'(ROUNDS_MAX_DEF);
               2:       rc = 16'd0;
               3:       rc = WORD_W'($urandom_range(ROUNDS_MAX_DEF + 1, 31));
               default: rc = WORD_W'($urandom_range(1, ROUNDS_MAX_DEF));
            endcase
            if ($urandom_range(0, 3) == 0) rc[WORD_W-1:RC_W] = (WORD_W-RC_W)'($urandom);
            write_register(CSR_ROUND_COUNT, rc);
         end
         if ($urandom_range(0, 5) == 0)
            write_register(CSR_IDX_W'($urandom_range(CSR_UNMAPPED_FIRST, CSR_UNMAPPED_LAST)),
                           pick_word());

         have_last = 1'b0;
         for (int n = 0; n < BLOCKS_PER_PH; n++) begin
            if (have_last && $urandom_range(0, 4) == 0) begin
               // feed the last result back the other way: must give the input back
               item.opcode      = ~item.opcode;
               item.block_left  = last_out.result_left;
               item.block_right = last_out.result_right;
            end else begin
               item.opcode      = 1'($urandom_range(0, 1));
               item.block_left  = pick_word();
               item.block_right = pick_word();
            end
            last_out  = cipher_block(item);
            have_last = 1'b1;
            send_block(item, 1'b0, '0);
         end
      end

      wait_drained();
      repeat (ROUNDS_MAX_DEF + 8) @(posedge clock);
      if (errors == 0)
         $display("testbench: done, clean");
      else
         $display("testbench: done, errors");
      $finish;
   end

endmodule

[files.f]
sv/spk_pkg.sv
sv/speck32_64_reduced_round_cipher.sv
sv/spk_checker.sv
tb/sv/testbench.sv
